@@ hw/rtl/stt_pkg.sv @@
// shared types, constants and lookup functions for the source text tokenizer
// no dependencies; used by the scanner, the result queue and the top level
package stt_pkg;

    localparam int unsigned MAX_TEXT_LENGTH = 65536;
    localparam int unsigned POS_W           = $clog2(MAX_TEXT_LENGTH);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(MAX_TEXT_LENGTH - 1);

    localparam logic [15:0] LEN_MAX        = 16'hFFFF;
    localparam logic [15:0] MAX_TOKENS_RST = 16'hFFFF;
    localparam int unsigned KW_MAX_LEN     = 6;

    localparam int unsigned RES_FIFO_DEPTH = 4;
    localparam int unsigned RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int unsigned RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

    // result kinds
    localparam logic [1:0] RK_TOKEN = 2'd0;
    localparam logic [1:0] RK_END   = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_UNKNOWN  = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED = 2'd1;
    localparam logic [1:0] ERR_BAD_NUM  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // token kinds
    localparam logic [5:0] TK_VOID    = 6'd0;
    localparam logic [5:0] TK_I16     = 6'd1;
    localparam logic [5:0] TK_U16     = 6'd2;
    localparam logic [5:0] TK_FN      = 6'd3;
    localparam logic [5:0] TK_IF      = 6'd4;
    localparam logic [5:0] TK_ELSE    = 6'd5;
    localparam logic [5:0] TK_WHILE   = 6'd6;
    localparam logic [5:0] TK_FOR     = 6'd7;
    localparam logic [5:0] TK_RETURN  = 6'd8;
    localparam logic [5:0] TK_LET     = 6'd9;
    localparam logic [5:0] TK_LITERAL = 6'd10;
    localparam logic [5:0] TK_IDENT   = 6'd11;
    localparam logic [5:0] TK_PLUS    = 6'd12;
    localparam logic [5:0] TK_MINUS   = 6'd13;
    localparam logic [5:0] TK_EQ      = 6'd14;
    localparam logic [5:0] TK_NE      = 6'd15;
    localparam logic [5:0] TK_GT      = 6'd16;
    localparam logic [5:0] TK_LT      = 6'd17;
    localparam logic [5:0] TK_GE      = 6'd18;
    localparam logic [5:0] TK_LE      = 6'd19;
    localparam logic [5:0] TK_LAND    = 6'd20;
    localparam logic [5:0] TK_LOR     = 6'd21;
    localparam logic [5:0] TK_NOT     = 6'd22;
    localparam logic [5:0] TK_AND     = 6'd23;
    localparam logic [5:0] TK_OR      = 6'd24;
    localparam logic [5:0] TK_XOR     = 6'd25;
    localparam logic [5:0] TK_TILDE   = 6'd26;
    localparam logic [5:0] TK_ASSIGN  = 6'd27;
    localparam logic [5:0] TK_SHL     = 6'd28;
    localparam logic [5:0] TK_SHR     = 6'd29;
    localparam logic [5:0] TK_DOT     = 6'd30;
    localparam logic [5:0] TK_LBRACE  = 6'd31;
    localparam logic [5:0] TK_RBRACE  = 6'd32;
    localparam logic [5:0] TK_LBRACK  = 6'd33;
    localparam logic [5:0] TK_RBRACK  = 6'd34;
    localparam logic [5:0] TK_LPAREN  = 6'd35;
    localparam logic [5:0] TK_RPAREN  = 6'd36;
    localparam logic [5:0] TK_SEMI    = 6'd37;
    localparam logic [5:0] TK_COLON   = 6'd38;
    localparam logic [5:0] TK_COMMA   = 6'd39;
    localparam logic [5:0] TK_ARROW   = 6'd40;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BLOCK_STAR,
        MODE_OPER,
        MODE_NUMBER,
        MODE_WORD,
        MODE_HALT
    } scan_mode_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [5:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [1:0]  error_code;
        logic [15:0] token_total;
        logic        last_of_run;
    } result_t;

    // results produced by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] kind;
    } kind_lookup_t;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || c == 8'h0A || c == 8'h0D || c == 8'h09;
    endfunction

    // first byte of a possible two-byte operator
    function automatic logic is_oper_lead(logic [7:0] c);
        return c == "-" || c == "<" || c == ">" || c == "=" || c == "!" ||
               c == "&" || c == "|";
    endfunction

    function automatic logic [15:0] clamp16(logic [POS_W-1:0] v);
        if (32'(v) > 32'hFFFF)
            return 16'hFFFF;
        else
            return 16'(v);
    endfunction

    function automatic kind_lookup_t single_kind(logic [7:0] c);
        kind_lookup_t r;
        r.hit  = 1'b1;
        r.kind = TK_PLUS;
        case (c)
            "+":     r.kind = TK_PLUS;
            "^":     r.kind = TK_XOR;
            "~":     r.kind = TK_TILDE;
            ".":     r.kind = TK_DOT;
            "{":     r.kind = TK_LBRACE;
            "}":     r.kind = TK_RBRACE;
            "[":     r.kind = TK_LBRACK;
            "]":     r.kind = TK_RBRACK;
            "(":     r.kind = TK_LPAREN;
            ")":     r.kind = TK_RPAREN;
            ";":     r.kind = TK_SEMI;
            ":":     r.kind = TK_COLON;
            ",":     r.kind = TK_COMMA;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic kind_lookup_t pair_kind(logic [7:0] p, logic [7:0] c);
        kind_lookup_t r;
        r.hit  = 1'b1;
        r.kind = TK_ARROW;
        if (p == "-" && c == ">")
            r.kind = TK_ARROW;
        else if (p == "<" && c == "<")
            r.kind = TK_SHL;
        else if (p == "<" && c == "=")
            r.kind = TK_LE;
        else if (p == ">" && c == ">")
            r.kind = TK_SHR;
        else if (p == ">" && c == "=")
            r.kind = TK_GE;
        else if (p == "=" && c == "=")
            r.kind = TK_EQ;
        else if (p == "!" && c == "=")
            r.kind = TK_NE;
        else if (p == "&" && c == "&")
            r.kind = TK_LAND;
        else if (p == "|" && c == "|")
            r.kind = TK_LOR;
        else
            r.hit = 1'b0;
        return r;
    endfunction

    function automatic logic [5:0] lone_kind(logic [7:0] p);
        logic [5:0] k;
        case (p)
            "-":     k = TK_MINUS;
            "<":     k = TK_LT;
            ">":     k = TK_GT;
            "=":     k = TK_ASSIGN;
            "!":     k = TK_NOT;
            "&":     k = TK_AND;
            default: k = TK_OR;
        endcase
        return k;
    endfunction

    // prefix holds the word's first bytes, last byte in the low bits
    function automatic kind_lookup_t keyword_kind(logic [15:0] len, logic [47:0] prefix);
        kind_lookup_t r;
        r.hit  = 1'b1;
        r.kind = TK_VOID;
        if (len == 16'd4 && prefix == 48'("void"))
            r.kind = TK_VOID;
        else if (len == 16'd3 && prefix == 48'("i16"))
            r.kind = TK_I16;
        else if (len == 16'd3 && prefix == 48'("u16"))
            r.kind = TK_U16;
        else if (len == 16'd4 && prefix == 48'("else"))
            r.kind = TK_ELSE;
        else if (len == 16'd5 && prefix == 48'("while"))
            r.kind = TK_WHILE;
        else if (len == 16'd3 && prefix == 48'("for"))
            r.kind = TK_FOR;
        else if (len == 16'd6 && prefix == 48'("return"))
            r.kind = TK_RETURN;
        else if (len == 16'd3 && prefix == 48'("let"))
            r.kind = TK_LET;
        else
            r.hit = 1'b0;
        return r;
    endfunction

    function automatic result_t make_result(logic [1:0] rk, logic [5:0] tk,
                                            logic [15:0] start, logic [15:0] len,
                                            logic [1:0] ec, logic [15:0] total);
        result_t r;
        r.result_kind  = rk;
        r.token_kind   = tk;
        r.token_start  = start;
        r.token_length = len;
        r.error_code   = ec;
        r.token_total  = total;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

@@ hw/rtl/stt_byte_if.sv @@
// input channel: one source byte per beat with valid/ready
// no dependencies
interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink   (input valid, input source_byte, output ready);
endinterface

@@ hw/rtl/stt_result_if.sv @@
// output channel: one token, end or error result per beat with valid/ready
// no dependencies
interface stt_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [1:0]  error_code;
    logic [15:0] token_total;
    logic        last_of_run;

    modport source (output valid, output result_kind, output token_kind,
                    output token_start, output token_length, output error_code,
                    output token_total, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input token_kind,
                    input token_start, input token_length, input error_code,
                    input token_total, input last_of_run, output ready);
endinterface

@@ hw/rtl/stt_scanner.sv @@
// scanner state registers and the per-byte next-state / result logic
// depends on stt_pkg
module stt_scanner
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_accept,
    input  logic [7:0]           source_byte,
    input  logic                 cfg_write_en,
    input  logic [15:0]          cfg_write_data,
    output stt_pkg::push_t       push
);

    stt_pkg::scan_mode_t           mode_reg, mode_next;
    logic [47:0]                   prefix_reg, prefix_next;
    logic [15:0]                   len_reg, len_next;
    logic                          kwp_reg, kwp_next;
    logic [7:0]                    pend_reg, pend_next;
    logic [stt_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [stt_pkg::POS_W-1:0]     start_reg, start_next;
    logic [15:0]                   count_reg, count_next;
    logic [15:0]                   max_tokens_reg;

    // first stage: the mode handler may emit a token or fail
    logic                          emit_a, fail_a, idle_after_a, do_idle;
    logic [5:0]                    emit_kind_a;
    logic [15:0]                   emit_len_a;
    logic [1:0]                    fail_code_a;
    logic                          fin;
    logic                          a_v, b_v, c_v;
    stt_pkg::result_t              res_a, res_b, res_c;
    stt_pkg::kind_lookup_t         pair_l, kw_l, single_l;
    logic [15:0]                   len_inc;
    logic [15:0]                   start16, pos16;
    logic [1:0]                    n_res;

    function automatic logic over_limit(logic [15:0] cnt, logic [15:0] mx);
        return ({1'b0, cnt} + 17'd1) >= {1'b0, mx};
    endfunction

    assign start16  = stt_pkg::clamp16(start_reg);
    assign pos16    = stt_pkg::clamp16(pos_reg);
    assign len_inc  = (len_reg != stt_pkg::LEN_MAX) ? len_reg + 16'd1 : len_reg;
    assign pair_l   = stt_pkg::pair_kind(pend_reg, source_byte);
    assign kw_l     = stt_pkg::keyword_kind(len_reg, prefix_reg);
    assign single_l = stt_pkg::single_kind(source_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= stt_pkg::MODE_IDLE;
            prefix_reg     <= '0;
            len_reg        <= '0;
            kwp_reg        <= 1'b0;
            pend_reg       <= '0;
            pos_reg        <= '0;
            start_reg      <= '0;
            count_reg      <= '0;
            max_tokens_reg <= stt_pkg::MAX_TOKENS_RST;
        end
        else
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            kwp_reg    <= kwp_next;
            pend_reg   <= pend_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            if (cfg_write_en)
                max_tokens_reg <= cfg_write_data;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        prefix_next  = prefix_reg;
        len_next     = len_reg;
        kwp_next     = kwp_reg;
        pend_next    = pend_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        emit_a       = 1'b0;
        fail_a       = 1'b0;
        idle_after_a = 1'b0;
        do_idle      = 1'b0;
        emit_kind_a  = stt_pkg::TK_VOID;
        emit_len_a   = '0;
        fail_code_a  = stt_pkg::ERR_UNKNOWN;
        fin          = 1'b0;
        a_v          = 1'b0;
        b_v          = 1'b0;
        c_v          = 1'b0;
        res_a        = '0;
        res_b        = '0;
        res_c        = '0;

        if (byte_accept)
        begin
            if (pos_reg < stt_pkg::POS_LAST)
                pos_next = pos_reg + stt_pkg::POS_W'(1);

            unique case (mode_reg)
                stt_pkg::MODE_HALT:
                begin
                end
                stt_pkg::MODE_SLASH:
                begin
                    if (source_byte == "/")
                        mode_next = stt_pkg::MODE_LINE;
                    else if (source_byte == "*")
                        mode_next = stt_pkg::MODE_BLOCK_STAR;
                    else
                    begin
                        fail_a      = 1'b1;
                        fail_code_a = stt_pkg::ERR_UNKNOWN;
                    end
                end
                stt_pkg::MODE_LINE:
                begin
                    if (source_byte == 8'h00)
                        fin = 1'b1;
                    else if (source_byte == 8'h0A)
                        mode_next = stt_pkg::MODE_IDLE;
                end
                stt_pkg::MODE_BLOCK, stt_pkg::MODE_BLOCK_STAR:
                begin
                    if (source_byte == 8'h00)
                    begin
                        fail_a      = 1'b1;
                        fail_code_a = stt_pkg::ERR_UNCLOSED;
                    end
                    else if (source_byte == "/" && mode_reg == stt_pkg::MODE_BLOCK_STAR)
                        mode_next = stt_pkg::MODE_IDLE;
                    else if (source_byte == "*")
                        mode_next = stt_pkg::MODE_BLOCK_STAR;
                    else
                        mode_next = stt_pkg::MODE_BLOCK;
                end
                stt_pkg::MODE_OPER:
                begin
                    emit_a = 1'b1;
                    if (pair_l.hit)
                        emit_kind_a = pair_l.kind;
                    else
                    begin
                        emit_kind_a  = stt_pkg::lone_kind(pend_reg);
                        idle_after_a = 1'b1;
                    end
                end
                stt_pkg::MODE_NUMBER:
                begin
                    if (stt_pkg::is_digit(source_byte))
                        len_next = len_inc;
                    else if (stt_pkg::is_alpha(source_byte))
                    begin
                        fail_a      = 1'b1;
                        fail_code_a = stt_pkg::ERR_BAD_NUM;
                    end
                    else
                    begin
                        emit_a       = 1'b1;
                        emit_kind_a  = stt_pkg::TK_LITERAL;
                        emit_len_a   = len_reg;
                        idle_after_a = 1'b1;
                    end
                end
                stt_pkg::MODE_WORD:
                begin
                    if (stt_pkg::is_alpha(source_byte) || stt_pkg::is_digit(source_byte))
                    begin
                        // fn and if are taken at their second letter
                        if (len_reg == 16'd1 && kwp_reg && prefix_reg[7:0] == "f" &&
                            source_byte == "n")
                        begin
                            emit_a      = 1'b1;
                            emit_kind_a = stt_pkg::TK_FN;
                        end
                        else if (len_reg == 16'd1 && kwp_reg && prefix_reg[7:0] == "i" &&
                                 source_byte == "f")
                        begin
                            emit_a      = 1'b1;
                            emit_kind_a = stt_pkg::TK_IF;
                        end
                        else
                        begin
                            if (len_reg < 16'(stt_pkg::KW_MAX_LEN))
                                prefix_next = {prefix_reg[39:0], source_byte};
                            len_next = len_inc;
                            if (len_inc > 16'(stt_pkg::KW_MAX_LEN))
                                kwp_next = 1'b0;
                        end
                    end
                    else if (kwp_reg && kw_l.hit)
                    begin
                        emit_a       = 1'b1;
                        emit_kind_a  = kw_l.kind;
                        idle_after_a = 1'b1;
                    end
                    else if (source_byte == "_")
                    begin
                        kwp_next = 1'b0;
                        len_next = len_inc;
                    end
                    else
                    begin
                        emit_a       = 1'b1;
                        emit_kind_a  = stt_pkg::TK_IDENT;
                        emit_len_a   = len_reg;
                        idle_after_a = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = stt_pkg::MODE_IDLE;
                    do_idle   = 1'b1;
                end
            endcase

            // token or error out of the mode handler
            if (fail_a)
            begin
                a_v       = 1'b1;
                res_a     = stt_pkg::make_result(stt_pkg::RK_ERROR, stt_pkg::TK_VOID,
                                                 start16, 16'd0, fail_code_a, 16'd0);
                mode_next = stt_pkg::MODE_HALT;
            end
            else if (emit_a)
            begin
                a_v = 1'b1;
                if (over_limit(count_reg, max_tokens_reg))
                begin
                    res_a     = stt_pkg::make_result(stt_pkg::RK_ERROR, stt_pkg::TK_VOID,
                                                     start16, 16'd0, stt_pkg::ERR_OVERFLOW,
                                                     16'd0);
                    mode_next = stt_pkg::MODE_HALT;
                end
                else
                begin
                    res_a      = stt_pkg::make_result(stt_pkg::RK_TOKEN, emit_kind_a,
                                                      start16, emit_len_a,
                                                      stt_pkg::ERR_UNKNOWN, 16'd0);
                    count_next = count_reg + 16'd1;
                    mode_next  = stt_pkg::MODE_IDLE;
                    do_idle    = idle_after_a;
                end
            end

            // the byte starts something new from between tokens
            if (do_idle)
            begin
                start_next = pos_reg;
                if (source_byte == 8'h00)
                    fin = 1'b1;
                else if (stt_pkg::is_space(source_byte))
                begin
                end
                else if (source_byte == "/")
                    mode_next = stt_pkg::MODE_SLASH;
                else if (stt_pkg::is_digit(source_byte))
                begin
                    mode_next = stt_pkg::MODE_NUMBER;
                    len_next  = 16'd1;
                end
                else if (stt_pkg::is_alpha(source_byte) || source_byte == "_")
                begin
                    mode_next   = stt_pkg::MODE_WORD;
                    len_next    = 16'd1;
                    prefix_next = {40'd0, source_byte};
                    kwp_next    = stt_pkg::is_alpha(source_byte);
                end
                else if (stt_pkg::is_oper_lead(source_byte))
                begin
                    mode_next = stt_pkg::MODE_OPER;
                    pend_next = source_byte;
                end
                else if (single_l.hit)
                begin
                    b_v = 1'b1;
                    if (over_limit(count_next, max_tokens_reg))
                    begin
                        res_b     = stt_pkg::make_result(stt_pkg::RK_ERROR, stt_pkg::TK_VOID,
                                                         pos16, 16'd0, stt_pkg::ERR_OVERFLOW,
                                                         16'd0);
                        mode_next = stt_pkg::MODE_HALT;
                    end
                    else
                    begin
                        res_b      = stt_pkg::make_result(stt_pkg::RK_TOKEN, single_l.kind,
                                                          pos16, 16'd0, stt_pkg::ERR_UNKNOWN,
                                                          16'd0);
                        count_next = count_next + 16'd1;
                        mode_next  = stt_pkg::MODE_IDLE;
                    end
                end
                else
                begin
                    b_v       = 1'b1;
                    res_b     = stt_pkg::make_result(stt_pkg::RK_ERROR, stt_pkg::TK_VOID,
                                                     pos16, 16'd0, stt_pkg::ERR_UNKNOWN, 16'd0);
                    mode_next = stt_pkg::MODE_HALT;
                end
            end

            // end byte: report the count and re-arm
            if (source_byte == 8'h00 && (fin || mode_next == stt_pkg::MODE_HALT))
            begin
                c_v         = 1'b1;
                res_c       = stt_pkg::make_result(stt_pkg::RK_END, stt_pkg::TK_VOID, pos16,
                                                   16'd0, stt_pkg::ERR_UNKNOWN, count_next);
                mode_next   = stt_pkg::MODE_IDLE;
                prefix_next = '0;
                len_next    = '0;
                kwp_next    = 1'b0;
                pend_next   = '0;
                start_next  = '0;
                count_next  = '0;
                pos_next    = '0;
            end
        end
    end

    // pack the present results in order, at most two per byte
    always_comb
    begin
        n_res       = 2'(a_v) + 2'(b_v) + 2'(c_v);
        push.count  = n_res;
        push.first  = a_v ? res_a : (b_v ? res_b : res_c);
        push.second = (a_v && b_v) ? res_b : res_c;
        if (n_res == 2'd1)
            push.first.last_of_run = 1'b1;
        else
            push.second.last_of_run = 1'b1;
    end

endmodule

@@ hw/rtl/stt_result_fifo.sv @@
// small result queue: takes up to two results per cycle, gives one per beat
// depends on stt_pkg
module stt_result_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::push_t     push,
    input  logic               pop,
    output logic               room,
    output logic               not_empty,
    output stt_pkg::result_t   head
);

    stt_pkg::result_t                  entry_reg [stt_pkg::RES_FIFO_DEPTH];
    logic [stt_pkg::RES_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [stt_pkg::RES_CNT_W-1:0]     count_reg, count_next;
    logic [stt_pkg::RES_PTR_W-1:0]     wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + stt_pkg::RES_PTR_W'(1);
    assign not_empty    = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    // a byte may bring two results, so keep two slots free before accepting
    assign room         = (count_reg <= stt_pkg::RES_CNT_W'(stt_pkg::RES_FIFO_DEPTH - 2));
    assign count_next   = count_reg + stt_pkg::RES_CNT_W'(push.count)
                          - stt_pkg::RES_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + stt_pkg::RES_PTR_W'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + stt_pkg::RES_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second;
    end

endmodule

@@ hw/rtl/source_text_tokenizer_unit.sv @@
// top level of the source text tokenizer: scanner plus result queue
// depends on stt_pkg, stt_byte_if, stt_result_if, stt_scanner, stt_result_fifo
//
//   channel      dir  payload                                         handshake
//   byte_in      in   source_byte                                     valid/ready
//   result_out   out  result_kind token_kind token_start token_length valid/ready
//                     error_code token_total last_of_run
//   cfg          in   cfg_write_data (max_tokens)                     cfg_write_en
//
// one byte is taken per cycle while ready is high; its zero, one or two results
// enter a four-entry queue in the same edge and leave one per beat from the
// following cycle; byte_in.ready is low only while the queue has fewer than two
// free entries, so a stalled result side holds off input once the queue fills
// rst_n clears the scanner state, the token count and the queue at once;
// max_tokens resets to 65535
module source_text_tokenizer_unit
(
    input  logic               clk,
    input  logic               rst_n,
    stt_byte_if.sink           byte_in,
    stt_result_if.source       result_out,
    input  logic               cfg_write_en,
    input  logic [15:0]        cfg_write_data
);

    stt_pkg::push_t     push;
    stt_pkg::result_t   head;
    logic               room;
    logic               not_empty;
    logic               byte_accept;
    logic               pop;

    assign byte_in.ready = room;
    assign byte_accept   = byte_in.valid && room;
    assign pop           = not_empty && result_out.ready;

    stt_scanner u_scanner
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_accept    (byte_accept),
        .source_byte    (byte_in.source_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .push           (push)
    );

    stt_result_fifo u_result_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .room      (room),
        .not_empty (not_empty),
        .head      (head)
    );

    assign result_out.valid        = not_empty;
    assign result_out.result_kind  = head.result_kind;
    assign result_out.token_kind   = head.token_kind;
    assign result_out.token_start  = head.token_start;
    assign result_out.token_length = head.token_length;
    assign result_out.error_code   = head.error_code;
    assign result_out.token_total  = head.token_total;
    assign result_out.last_of_run  = head.last_of_run;

endmodule

@@ dv/stt_tokenizer_checker.sv @@
`timescale 1ns / 100ps
// scoreboard for the source text tokenizer: predicts the results of every
// accepted byte beat and compares them with the result channel in order
// depends on stt_pkg, stt_byte_if and stt_result_if
module stt_tokenizer_checker
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    stt_byte_if         byte_ch,
    stt_result_if       result_ch,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    output int          fail_count,
    output int          pending_results,
    output int          results_checked,
    output int          errors_seen,
    output int          ends_seen
);

    localparam logic [7:0] END_BYTE = 8'h00;
    localparam logic [7:0] LF       = 8'h0A;
    localparam logic [5:0] NO_KIND  = 6'd0;
    localparam logic [1:0] NO_ERROR = 2'd0;

    // scanner state as the block should hold it
    scan_mode_t  mode;
    logic [47:0] word_bytes;
    logic [15:0] word_len;
    logic        kw_maybe;
    logic [7:0]  op_lead;
    logic [15:0] text_pos;
    logic [15:0] tok_begin;
    logic [15:0] tok_count;
    logic [15:0] max_tokens;

    result_t     step_res[2];
    int          step_n;
    result_t     expected_results[$];

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == " " || c == LF || c == 8'h0D || c == 8'h09;
    endfunction

    function automatic logic is_lead(logic [7:0] c);
        return c == "-" || c == "<" || c == ">" || c == "=" || c == "!" ||
               c == "&" || c == "|";
    endfunction

    function automatic kind_lookup_t punct_token(logic [7:0] c);
        kind_lookup_t r;
        r.hit = 1'b1;
        case (c)
            "+":     r.kind = TK_PLUS;
            "^":     r.kind = TK_XOR;
            "~":     r.kind = TK_TILDE;
            ".":     r.kind = TK_DOT;
            "{":     r.kind = TK_LBRACE;
            "}":     r.kind = TK_RBRACE;
            "[":     r.kind = TK_LBRACK;
            "]":     r.kind = TK_RBRACK;
            "(":     r.kind = TK_LPAREN;
            ")":     r.kind = TK_RPAREN;
            ";":     r.kind = TK_SEMI;
            ":":     r.kind = TK_COLON;
            ",":     r.kind = TK_COMMA;
            default:
            begin
                r.hit  = 1'b0;
                r.kind = NO_KIND;
            end
        endcase
        return r;
    endfunction

    function automatic kind_lookup_t pair_token(logic [7:0] p, logic [7:0] c);
        kind_lookup_t r;
        r.hit = 1'b1;
        case ({p, c})
            "->":    r.kind = TK_ARROW;
            "<<":    r.kind = TK_SHL;
            "<=":    r.kind = TK_LE;
            ">>":    r.kind = TK_SHR;
            ">=":    r.kind = TK_GE;
            "==":    r.kind = TK_EQ;
            "!=":    r.kind = TK_NE;
            "&&":    r.kind = TK_LAND;
            "||":    r.kind = TK_LOR;
            default:
            begin
                r.hit  = 1'b0;
                r.kind = NO_KIND;
            end
        endcase
        return r;
    endfunction

    function automatic logic [5:0] lone_token(logic [7:0] p);
        case (p)
            "-":     return TK_MINUS;
            "<":     return TK_LT;
            ">":     return TK_GT;
            "=":     return TK_ASSIGN;
            "!":     return TK_NOT;
            "&":     return TK_AND;
            default: return TK_OR;
        endcase
    endfunction

    // letters and digits are never zero, so the packed bytes fix the length
    function automatic kind_lookup_t keyword_token();
        kind_lookup_t r;
        r.hit = 1'b1;
        case (word_bytes)
            48'("void"):   r.kind = TK_VOID;
            48'("i16"):    r.kind = TK_I16;
            48'("u16"):    r.kind = TK_U16;
            48'("else"):   r.kind = TK_ELSE;
            48'("while"):  r.kind = TK_WHILE;
            48'("for"):    r.kind = TK_FOR;
            48'("return"): r.kind = TK_RETURN;
            48'("let"):    r.kind = TK_LET;
            default:
            begin
                r.hit  = 1'b0;
                r.kind = NO_KIND;
            end
        endcase
        return r;
    endfunction

    function automatic void add_result(logic [1:0] rk, logic [5:0] tk, logic [15:0] start,
                                       logic [15:0] len, logic [1:0] ec, logic [15:0] total);
        if (step_n < 2)
        begin
            step_res[step_n] = '{rk, tk, start, len, ec, total, 1'b0};
            step_n++;
        end
    endfunction

    function automatic void raise_error(logic [1:0] code, logic [15:0] start);
        add_result(RK_ERROR, NO_KIND, start, 16'd0, code, 16'd0);
        mode = MODE_HALT;
    endfunction

    function automatic bit store_token(logic [5:0] kind, logic [15:0] start, logic [15:0] len);
        if ({1'b0, tok_count} + 17'd1 >= {1'b0, max_tokens})
        begin
            raise_error(ERR_OVERFLOW, start);
            return 1'b0;
        end
        add_result(RK_TOKEN, kind, start, len, NO_ERROR, 16'd0);
        tok_count = tok_count + 16'd1;
        mode      = MODE_IDLE;
        return 1'b1;
    endfunction

    function automatic void close_text(logic [15:0] pos);
        add_result(RK_END, NO_KIND, pos, 16'd0, NO_ERROR, tok_count);
        mode       = MODE_IDLE;
        word_bytes = '0;
        word_len   = '0;
        kw_maybe   = 1'b0;
        op_lead    = '0;
        tok_begin  = '0;
        tok_count  = '0;
        text_pos   = '0;
    endfunction

    function automatic void scan_idle(logic [7:0] c, logic [15:0] pos);
        kind_lookup_t p;
        p         = punct_token(c);
        tok_begin = pos;
        if (c == END_BYTE)
            close_text(pos);
        else if (c == "/")
            mode = MODE_SLASH;
        else if (is_numeral(c))
        begin
            mode     = MODE_NUMBER;
            word_len = 16'd1;
        end
        else if (is_letter(c) || c == "_")
        begin
            mode       = MODE_WORD;
            word_len   = 16'd1;
            word_bytes = {40'd0, c};
            kw_maybe   = is_letter(c);
        end
        else if (is_lead(c))
        begin
            mode    = MODE_OPER;
            op_lead = c;
        end
        else if (p.hit)
            void'(store_token(p.kind, pos, 16'd0));
        else if (!is_blank(c))
            raise_error(ERR_UNKNOWN, pos);
    endfunction

    function automatic void scan_word(logic [7:0] c, logic [15:0] pos);
        kind_lookup_t kw;
        if (is_letter(c) || is_numeral(c))
        begin
            // fn and if are taken at their second letter, no boundary needed
            if (word_len == 16'd1 && kw_maybe)
            begin
                if (word_bytes[7:0] == "f" && c == "n")
                begin
                    void'(store_token(TK_FN, tok_begin, 16'd0));
                    return;
                end
                if (word_bytes[7:0] == "i" && c == "f")
                begin
                    void'(store_token(TK_IF, tok_begin, 16'd0));
                    return;
                end
            end
            if (word_len < 16'd6)
                word_bytes = {word_bytes[39:0], c};
            if (word_len != LEN_MAX)
                word_len = word_len + 16'd1;
            if (word_len > 16'd6)
                kw_maybe = 1'b0;
            return;
        end
        if (kw_maybe)
        begin
            kw = keyword_token();
            if (kw.hit)
            begin
                if (store_token(kw.kind, tok_begin, 16'd0))
                    scan_idle(c, pos);
                return;
            end
        end
        if (c == "_")
        begin
            kw_maybe = 1'b0;
            if (word_len != LEN_MAX)
                word_len = word_len + 16'd1;
            return;
        end
        if (store_token(TK_IDENT, tok_begin, word_len))
            scan_idle(c, pos);
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        logic [15:0]  pos;
        kind_lookup_t pr;
        pos    = text_pos;
        step_n = 0;
        if (text_pos != POS_LAST)
            text_pos = text_pos + 16'd1;
        case (mode)
            MODE_HALT:
                if (c == END_BYTE)
                    close_text(pos);
            MODE_SLASH:
                if (c == "/")
                    mode = MODE_LINE;
                else if (c == "*")
                    mode = MODE_BLOCK_STAR;
                else
                    raise_error(ERR_UNKNOWN, tok_begin);
            MODE_LINE:
                if (c == END_BYTE)
                    close_text(pos);
                else if (c == LF)
                    mode = MODE_IDLE;
            MODE_BLOCK, MODE_BLOCK_STAR:
                // the star of the opening may close the comment
                if (c == END_BYTE)
                    raise_error(ERR_UNCLOSED, tok_begin);
                else if (c == "/" && mode == MODE_BLOCK_STAR)
                    mode = MODE_IDLE;
                else
                    mode = (c == "*") ? MODE_BLOCK_STAR : MODE_BLOCK;
            MODE_OPER:
            begin
                pr = pair_token(op_lead, c);
                if (pr.hit)
                    void'(store_token(pr.kind, tok_begin, 16'd0));
                else if (store_token(lone_token(op_lead), tok_begin, 16'd0))
                    scan_idle(c, pos);
            end
            MODE_NUMBER:
                if (is_numeral(c))
                begin
                    if (word_len != LEN_MAX)
                        word_len = word_len + 16'd1;
                end
                else if (is_letter(c))
                    raise_error(ERR_BAD_NUM, tok_begin);
                else if (store_token(TK_LITERAL, tok_begin, word_len))
                    scan_idle(c, pos);
            MODE_WORD:
                scan_word(c, pos);
            default:
            begin
                mode = MODE_IDLE;
                scan_idle(c, pos);
            end
        endcase
        // an error raised by the end byte is followed by the end result
        if (c == END_BYTE && mode == MODE_HALT)
            close_text(pos);
        if (step_n > 0)
            step_res[step_n - 1].last_of_run = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_results.push_back(step_res[i]);
    endfunction

    function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
        if (want === got)
            return 0;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            mode            = MODE_IDLE;
            word_bytes      = '0;
            word_len        = '0;
            kw_maybe        = 1'b0;
            op_lead         = '0;
            text_pos        = '0;
            tok_begin       = '0;
            tok_count       = '0;
            max_tokens      = MAX_TOKENS_RST;
            expected_results.delete();
            fail_count      = 0;
            results_checked = 0;
            errors_seen     = 0;
            ends_seen       = 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_write_en)
                max_tokens = cfg_write_data;
            if (result_ch.valid && result_ch.ready)
            begin
                seen = '{result_ch.result_kind, result_ch.token_kind, result_ch.token_start,
                         result_ch.token_length, result_ch.error_code, result_ch.token_total,
                         result_ch.last_of_run};
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: result_kind %0d start %0d",
                           seen.result_kind, seen.token_start);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    fail_count += field_diff("result_kind", want.result_kind, seen.result_kind)
                        + field_diff("token_kind", want.token_kind, seen.token_kind)
                        + field_diff("token_start", want.token_start, seen.token_start)
                        + field_diff("token_length", want.token_length, seen.token_length)
                        + field_diff("error_code", want.error_code, seen.error_code)
                        + field_diff("token_total", want.token_total, seen.token_total)
                        + field_diff("last_of_run", want.last_of_run, seen.last_of_run);
                end
                results_checked++;
                if (seen.result_kind == RK_ERROR)
                    errors_seen++;
                if (seen.result_kind == RK_END)
                    ends_seen++;
            end
            if (byte_ch.valid && byte_ch.ready)
                predict_byte(byte_ch.source_byte);
            pending_results <= expected_results.size();
        end
    end

endmodule

@@ dv/tb_source_text_tokenizer_unit.sv @@
`timescale 1ns / 100ps
// testbench top for the source text tokenizer: drives source texts and the
// token limit, stalls the result side, and reports the checker's verdict
// depends on stt_pkg, stt_byte_if, stt_result_if, stt_tokenizer_checker and the block
module tb_source_text_tokenizer_unit;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int          RANDOM_BYTES = 360;
    localparam logic [7:0]  END_BYTE     = 8'h00;
    localparam logic [7:0]  LF           = 8'h0A;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [15:0] cfg_write_data;
    logic        no_idle;

    int          fail_count;
    int          pending_results;
    int          results_checked;
    int          errors_seen;
    int          ends_seen;
    int          texts_sent;
    int          bytes_sent;
    int          random_bytes;

    logic [7:0]  text_buf[$];

    string kw_words[10] = '{"void", "i16", "u16", "fn", "if", "else", "while", "for",
                            "return", "let"};
    string op_pairs[9]  = '{"->", "<<", "<=", ">>", ">=", "==", "!=", "&&", "||"};
    string ALNUM   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string DIGITS  = "0123456789";
    string LEADS   = "-<>=!&|";
    string PUNCT   = "+^~.{}[]();:,";
    string BLANKS  = " \n\r\t";

    stt_byte_if   byte_ch();
    stt_result_if result_ch();

    source_text_tokenizer_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_in        (byte_ch),
        .result_out     (result_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    stt_tokenizer_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_ch         (byte_ch),
        .result_ch       (result_ch),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .errors_seen     (errors_seen),
        .ends_seen       (ends_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // valid stays high from one beat to the next when no gap is drawn
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.source_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i]);
        send_byte(END_BYTE);
        texts_sent++;
        text_buf.delete();
    endtask

    task automatic text_from(string s);
        push_text(s);
        send_text();
    endtask

    // wait until every expected result has left
    task automatic settle();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_tokens(input logic [15:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 16'd1;
            1:       return 16'd2;
            2:       return 16'($urandom_range(3, 12));
            3:       return 16'hFFFF;
            4:       return 16'($urandom_range(1, 65535));
            default: return 16'($urandom_range(13, 64));
        endcase
    endfunction

    task automatic add_piece();
        logic [7:0] ch;
        case ($urandom_range(0, 15))
            0, 1:
            begin
                push_text(kw_words[$urandom_range(0, 9)]);
                if ($urandom_range(0, 3) == 0)
                    text_buf.push_back(pick(ALNUM));
            end
            2, 3:
            begin
                do
                    ch = pick(ALNUM);
                while (ch >= "0" && ch <= "9");
                text_buf.push_back(ch);
                repeat ($urandom_range(0, 9))
                    text_buf.push_back(pick(ALNUM));
            end
            4, 15:
            begin
                repeat ($urandom_range(1, 5))
                    text_buf.push_back(pick(DIGITS));
                if ($urandom_range(0, 5) == 0)
                    text_buf.push_back(pick(LETTERS));
            end
            5, 6:
                push_text(op_pairs[$urandom_range(0, 8)]);
            7:
                text_buf.push_back(pick(LEADS));
            8, 9:
                text_buf.push_back(pick(PUNCT));
            10:
                text_buf.push_back(pick(BLANKS));
            11:
            begin
                push_text("//");
                repeat ($urandom_range(0, 6))
                begin
                    do
                        ch = 8'($urandom_range(1, 255));
                    while (ch == LF);
                    text_buf.push_back(ch);
                end
                if ($urandom_range(0, 4) != 0)
                    text_buf.push_back(LF);
            end
            12:
            begin
                if ($urandom_range(0, 3) == 0)
                    push_text("/*/");
                else
                begin
                    push_text("/*");
                    repeat ($urandom_range(0, 6))
                        text_buf.push_back(8'($urandom_range(1, 255)));
                    if ($urandom_range(0, 7) != 0)
                        push_text("*/");
                end
            end
            13:
                text_buf.push_back(8'($urandom_range(1, 255)));
            default:
                text_buf.push_back("/");
        endcase
    endtask

    // result side: a fresh random stall, possibly none, before every result beat
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("source_text_tokenizer_unit: mismatch");
        $finish;
    end

    initial
    begin
        int text_no;
        rst_n               <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.source_byte <= 8'h00;
        cfg_write_en        <= 1'b0;
        cfg_write_data      <= 16'h0000;
        no_idle      = 1'b0;
        texts_sent   = 0;
        bytes_sent   = 0;
        random_bytes = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fn/if without boundary, arrow, comment closed by its own star
        text_from("fnifx->/*/y");
        // keyword ended by an underscore that starts a new word, then a digit run hitting a letter
        text_from("let_ 9a");
        // lone slash and open comment, both ended by the end byte
        text_from("/");
        text_from("/*");
        text_buf.push_back(8'hFF);
        send_text();
        settle();
        write_max_tokens(16'd1);
        text_from("+");
        settle();
        write_max_tokens(16'hFFFF);

        text_no = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            if (text_no % 4 == 0)
            begin
                settle();
                write_max_tokens(pick_limit());
            end
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 12))
            begin
                add_piece();
                if ($urandom_range(0, 1) == 0)
                    text_buf.push_back(pick(BLANKS));
            end
            random_bytes += text_buf.size() + 1;
            send_text();
            text_no++;
        end
        settle();

        $display("%0d texts, %0d source bytes sent; %0d results compared", texts_sent,
                 bytes_sent, results_checked);
        $display("%0d error results and %0d end results among them", errors_seen, ends_seen);
        if (fail_count == 0)
            $display("source_text_tokenizer_unit: match");
        else
            $display("source_text_tokenizer_unit: mismatch");
        $finish;
    end

endmodule

@@ source_text_tokenizer_unit.f @@
hw/rtl/stt_pkg.sv
hw/rtl/stt_byte_if.sv
hw/rtl/stt_result_if.sv
hw/rtl/stt_scanner.sv
hw/rtl/stt_result_fifo.sv
hw/rtl/source_text_tokenizer_unit.sv
dv/stt_tokenizer_checker.sv
dv/tb_source_text_tokenizer_unit.sv
